/* sv/sorted_int_set_range_query_top_macros.svh */
// Assertion macros for the sorted set block.
`ifndef SORTED_INT_SET_RANGE_QUERY_TOP_MACROS_SVH
`define SORTED_INT_SET_RANGE_QUERY_TOP_MACROS_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define SIS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that an antecedent implies a consequent in the next cycle.
`define SIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/sis_pkg.sv */
package sis_pkg;
  localparam int Capacity = 64;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);
  localparam int QDepth = 2;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_RANGE  = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] key_value;
    logic signed [31:0] range_high;
  } req_t;

  typedef struct packed {
    logic               result_kind;
    logic               found;
    logic signed [31:0] item_value;
    logic               last_item;
  } res_t;
endpackage

/* sv/sis_if.sv */
interface sis_req_if import sis_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface sis_res_if import sis_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* sv/sis_ram.sv */
module sis_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* sv/sis_front.sv */
// Accepts requests, drops unused codes and queues the rest for the engine.
module sis_front import sis_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  sis_req_if.sink in_ch,
  output logic q_valid,
  output req_t q_data,
  input  logic q_pop
);
  req_t q_r [QDepth];
  logic [$clog2(QDepth)-1:0] wp_r, rp_r;
  logic [$clog2(QDepth):0] cnt_r;
  logic push, keep;

  assign in_ch.ready = (cnt_r != ($clog2(QDepth)+1)'(QDepth));
  assign keep = (in_ch.data.req_type != REQ_UNUSED);
  assign push = in_ch.valid && in_ch.ready && keep;
  assign q_valid = (cnt_r != '0);
  assign q_data = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (q_pop && q_valid) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (($clog2(QDepth)+1)'(push)) - (($clog2(QDepth)+1)'(q_pop && q_valid));
    end
    if (push) begin
      q_r[wp_r] <= in_ch.data;
    end
  end
endmodule

/* sv/sis_back.sv */
// Executes one request at a time by walking the table through the RAM.
module sis_back import sis_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  req_t q_data,
  output logic q_pop,
  sis_res_if.source out_ch,
  output logic busy
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;

  logic [2:0] st_r, st_nxt;
  req_t req_r, req_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [CntW-1:0] idx_r, idx_nxt;
  logic pend_r, pend_nxt;
  logic signed [31:0] pval_r, pval_nxt;
  logic out_v_r, out_v_nxt;
  res_t out_r, out_nxt;
  logic hit_r, hit_nxt;

  logic we;
  logic [IdxW-1:0] waddr, raddr;
  logic [31:0] wdata, rdata;
  logic signed [31:0] rv;

  sis_ram #(.Width(32), .Depth(Capacity)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign rv = signed'(rdata);
  assign out_ch.valid = out_v_r;
  assign out_ch.data = out_r;
  assign busy = (st_r != S_IDLE) || out_v_r;

  always_comb begin
    st_nxt = st_r;
    req_nxt = req_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    pend_nxt = 1'b0;
    pval_nxt = pval_r;
    hit_nxt = hit_r;
    out_v_nxt = out_v_r && !out_ch.ready;
    out_nxt = out_r;
    q_pop = 1'b0;
    we = 1'b0;
    waddr = idx_r[IdxW-1:0];
    wdata = req_r.key_value;
    raddr = idx_r[IdxW-1:0];
    unique case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          req_nxt = q_data;
          idx_nxt = '0;
          hit_nxt = 1'b0;
          raddr = '0;
          pend_nxt = 1'b1;
          st_nxt = (q_data.req_type == REQ_RANGE) ? S_EMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        // Walk ascending until key position is found.
        if (idx_r == cnt_r || (pend_r && rv >= req_r.key_value)) begin
          if (req_r.req_type == REQ_SEARCH) begin
            if (!out_v_r || out_ch.ready) begin
              out_v_nxt = 1'b1;
              out_nxt = '{result_kind: 1'b0,
                          found: (idx_r != cnt_r) && rv == req_r.key_value,
                          item_value: '0, last_item: 1'b1};
              st_nxt = S_IDLE;
            end else begin
              pend_nxt = pend_r;
            end
          end else if ((idx_r != cnt_r && rv == req_r.key_value) ||
                       cnt_r == CntW'(Capacity)) begin
            st_nxt = S_IDLE;
          end else begin
            // Shift from idx_r up to the top.
            pval_nxt = req_r.key_value;
            hit_nxt = 1'b0;
            st_nxt = S_SHIFT;
            raddr = idx_r[IdxW-1:0];
            pend_nxt = 1'b1;
          end
        end else if (pend_r) begin
          idx_nxt = idx_r + 1'b1;
          raddr = idx_nxt[IdxW-1:0];
          pend_nxt = 1'b1;
        end else begin
          raddr = idx_r[IdxW-1:0];
          pend_nxt = 1'b1;
        end
      end
      S_SHIFT: begin
        // Ripple upward: write carried value, carry out old entry.
        we = 1'b1;
        wdata = pval_r;
        if (idx_r == cnt_r) begin
          cnt_nxt = cnt_r + 1'b1;
          st_nxt = S_IDLE;
        end else if (pend_r) begin
          pval_nxt = rv;
          idx_nxt = idx_r + 1'b1;
          raddr = idx_nxt[IdxW-1:0];
          pend_nxt = 1'b1;
          we = 1'b1;
        end else begin
          we = 1'b0;
          raddr = idx_r[IdxW-1:0];
          pend_nxt = 1'b1;
        end
      end
      S_EMIT: begin
        // hit_r holds whether an earlier match awaits output in pval_r.
        if (!pend_r) begin
          raddr = idx_r[IdxW-1:0];
          pend_nxt = 1'b1;
        end else if (out_v_r && !out_ch.ready) begin
          pend_nxt = 1'b1;
        end else if (idx_r == cnt_r) begin
          if (hit_r) begin
            out_v_nxt = 1'b1;
            out_nxt = '{result_kind: 1'b1, found: 1'b0, item_value: pval_r, last_item: 1'b1};
          end
          st_nxt = S_IDLE;
        end else begin
          if (rv >= req_r.key_value && rv <= req_r.range_high) begin
            if (hit_r) begin
              out_v_nxt = 1'b1;
              out_nxt = '{result_kind: 1'b1, found: 1'b0, item_value: pval_r, last_item: 1'b0};
            end
            hit_nxt = 1'b1;
            pval_nxt = rv;
          end
          idx_nxt = idx_r + 1'b1;
          raddr = idx_nxt[IdxW-1:0];
          pend_nxt = 1'b1;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= '0;
      out_v_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      out_v_r <= out_v_nxt;
      pend_r <= pend_nxt;
    end
    req_r <= req_nxt;
    idx_r <= idx_nxt;
    pval_r <= pval_nxt;
    hit_r <= hit_nxt;
    out_r <= out_nxt;
  end
endmodule

/* sv/sorted_int_set_range_query_top.sv */
// Sorted set of distinct signed 32-bit values with insert, search and range
// query. Requests enter a two-item queue, so the input keeps accepting while
// the engine works; request code 3 is dropped at the input. The engine reads
// the table from one RAM with a single read and a single write port, one entry
// per cycle while no waiting result is held by the receiver. After taking the
// item from the queue, a search scans up to the first entry not below the key,
// an insert scans to its position and then ripples the entries above it up by
// one, and a range query visits every stored entry once. Results leave through
// an output register; each range value is held back until the next match or
// the end of the scan is seen, so the last one can be marked.
module sorted_int_set_range_query_top import sis_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  sis_req_if.sink   in_ch,
  sis_res_if.source out_ch
);
  `include "sorted_int_set_range_query_top_macros.svh"

  logic q_valid, q_pop, busy;
  req_t q_data;

  sis_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
  );

  sis_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data),
    .q_pop(q_pop), .out_ch(out_ch), .busy(busy)
  );

  // The engine only takes work from a nonempty queue.
  `SIS_ASSERT_IMPL(a_pop_valid, q_pop, q_valid, "pop from empty queue")
  // A search answer is always the last result of its request.
  `SIS_ASSERT_IMPL(a_search_last, out_ch.valid && !out_ch.data.result_kind,
                   out_ch.data.last_item, "search answer without last mark")
  // A pending result implies the engine reports busy.
  `SIS_ASSERT_IMPL(a_busy, out_ch.valid, busy, "result pending while idle")
endmodule

/* tb/testbench.sv */
module testbench;
  import sis_pkg::*;

  localparam int RandomItems = 192;
  localparam int CycleLimit = 1000000;
  localparam logic signed [31:0] MinVal = 32'sh8000_0000;
  localparam logic signed [31:0] MaxVal = 32'sh7fff_ffff;

  // One row of the directed stimulus. When typed is set, the row carries its
  // own expected search answer, which is used in place of the prediction.
  typedef struct {
    req_t req;
    bit   typed;
    res_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;

  // Idle rates in percent, changed between phases of the run.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Software copy of the table and the results still owed by the block.
  logic signed [31:0] set_vals[$];
  res_t pending_results[$];

  sis_req_if req_ch();
  sis_res_if res_ch();

  sorted_int_set_range_query_top DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(req_ch),
    .out_ch(res_ch)
  );

  always #6 clk = ~clk;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    res_ch.ready = 1'b0;
  end

  // Cycle counter and watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("sorted_int_set_range_query_top: mismatch");
      $finish;
    end
  end

  // The receiver stalls at random at the rate of the current phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Every result is compared with the oldest outstanding expectation.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind=%0b found=%0b value=%0d last=%0b", $time,
                 res_ch.data.result_kind, res_ch.data.found, res_ch.data.item_value,
                 res_ch.data.last_item);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (res_ch.data !== want) begin
          $display("%0t: expected kind=%0b found=%0b value=%0d last=%0b", $time,
                   want.result_kind, want.found, want.item_value, want.last_item);
          $display("%0t:   actual kind=%0b found=%0b value=%0d last=%0b", $time,
                   res_ch.data.result_kind, res_ch.data.found, res_ch.data.item_value,
                   res_ch.data.last_item);
          fail_count++;
        end
      end
    end
  end

  // Applies one request to the table copy and queues the results it causes.
  function automatic void predict_set_request(req_t r);
    int pos;
    int last_idx;
    res_t res;
    pos = 0;
    last_idx = -1;
    case (r.req_type)
      REQ_INSERT: begin
        while (pos < set_vals.size() && set_vals[pos] < r.key_value) pos++;
        if ((pos < set_vals.size() && set_vals[pos] == r.key_value) ||
            set_vals.size() >= Capacity) return;
        set_vals.insert(pos, r.key_value);
      end
      REQ_SEARCH: begin
        res = '0;
        res.last_item = 1'b1;
        foreach (set_vals[i]) if (set_vals[i] == r.key_value) res.found = 1'b1;
        pending_results.push_back(res);
      end
      REQ_RANGE: begin
        foreach (set_vals[i]) begin
          if (set_vals[i] >= r.key_value && set_vals[i] <= r.range_high) begin
            res = '0;
            res.result_kind = 1'b1;
            res.item_value = set_vals[i];
            pending_results.push_back(res);
            last_idx = pending_results.size() - 1;
          end
        end
        // Only the final value of the scan is marked as the last item.
        if (last_idx >= 0) pending_results[last_idx].last_item = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Presents one request and returns once it has been accepted. A gap, if
  // any, drops valid first; valid otherwise stays high between items.
  task automatic send_request(req_t r, bit typed, res_t want);
    if ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    do @(posedge clk); while (!req_ch.ready);
    if (typed) pending_results.push_back(want);
    else predict_set_request(r);
  endtask

  function automatic stim_row_t make_row(logic [1:0] kind, logic signed [31:0] key,
                                         logic signed [31:0] high, bit typed, bit hit);
    stim_row_t row;
    row.req = '{req_type: kind, key_value: key, range_high: high};
    row.typed = typed;
    row.want = '0;
    row.want.found = hit;
    row.want.last_item = 1'b1;
    return row;
  endfunction

  // Draws a key that often hits a stored value or its neighbors, so that
  // duplicates and exact range bounds come up regularly.
  function automatic logic signed [31:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(9);
    if (set_vals.size() > 0 && sel < 4)
      return set_vals[$urandom_range(set_vals.size() - 1)] + $signed($urandom_range(2)) - 1;
    if (sel < 6) return $signed($urandom_range(200)) - 100;
    return $urandom();
  endfunction

  function automatic req_t random_request();
    req_t r;
    int unsigned sel;
    logic signed [31:0] a;
    logic signed [31:0] b;
    sel = $urandom_range(99);
    a = pick_key();
    b = pick_key();
    r.range_high = $urandom();
    r.key_value = a;
    if (sel < 45) begin
      r.req_type = REQ_INSERT;
    end else if (sel < 70) begin
      r.req_type = REQ_SEARCH;
    end else if (sel < 95) begin
      r.req_type = REQ_RANGE;
      // Mostly ordered bounds; now and then a reversed or unbounded window.
      if ($urandom_range(9) == 0) begin
        r.key_value = (a > b) ? a : b;
        r.range_high = (a > b) ? b : a;
      end else if ($urandom_range(9) == 0) begin
        r.key_value = MinVal;
        r.range_high = MaxVal;
      end else begin
        r.key_value = (a < b) ? a : b;
        r.range_high = (a < b) ? b : a;
      end
    end else begin
      r.req_type = REQ_UNUSED;
    end
    return r;
  endfunction

  initial begin
    stim_row_t rows[$];
    req_t r;

    // Searches and ranges on the empty table, extremes of the value range,
    // a duplicate, reversed bounds and the unused request code.
    rows.push_back(make_row(REQ_SEARCH, 32'sd0, 32'sd0, 1, 0));
    rows.push_back(make_row(REQ_RANGE, MinVal, MaxVal, 0, 0));
    rows.push_back(make_row(REQ_INSERT, MinVal, MaxVal, 0, 0));
    rows.push_back(make_row(REQ_INSERT, MaxVal, MinVal, 0, 0));
    rows.push_back(make_row(REQ_INSERT, 32'sd0, 32'sd0, 0, 0));
    rows.push_back(make_row(REQ_INSERT, -32'sd1, 32'sd0, 0, 0));
    rows.push_back(make_row(REQ_INSERT, 32'sd0, 32'sd5, 0, 0));
    rows.push_back(make_row(REQ_SEARCH, MinVal, 32'sd0, 1, 1));
    rows.push_back(make_row(REQ_SEARCH, MaxVal, 32'sd0, 1, 1));
    rows.push_back(make_row(REQ_SEARCH, -32'sd1, 32'sd0, 1, 1));
    rows.push_back(make_row(REQ_SEARCH, 32'sd1, 32'sd0, 1, 0));
    rows.push_back(make_row(REQ_RANGE, MinVal, MaxVal, 0, 0));
    rows.push_back(make_row(REQ_RANGE, -32'sd1, 32'sd0, 0, 0));
    rows.push_back(make_row(REQ_RANGE, 32'sd0, -32'sd1, 0, 0));
    rows.push_back(make_row(REQ_RANGE, 32'sd1, 32'sd100, 0, 0));
    rows.push_back(make_row(REQ_RANGE, MaxVal, MaxVal, 0, 0));
    rows.push_back(make_row(REQ_UNUSED, 32'sd7, 32'sd9, 0, 0));
    rows.push_back(make_row(REQ_SEARCH, 32'sd7, 32'sd0, 1, 0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].want);

    // Random part in four idling phases. The table fills as it goes, so the
    // later inserts also hit the full table.
    for (int n = 0; n < RandomItems; n++) begin
      case (n * 4 / RandomItems)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 72; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 72; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      if (n == RandomItems / 2) begin
        // Hold the sender until the block has drained every result.
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      r = random_request();
      send_request(r, 1'b0, '0);
    end
    req_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    if (fail_count == 0) begin
      $display("sorted_int_set_range_query_top: match");
    end else begin
      $display("sorted_int_set_range_query_top: mismatch");
    end
    $finish;
  end
endmodule
